/* rtl/core/line_pixel_generator_defines.svh */
// ---------------------------------------------------------------------------
// line_pixel_generator_defines
// Assertion macros shared by the line pixel generator RTL.
// ---------------------------------------------------------------------------
`ifndef LINE_PIXEL_GENERATOR_DEFINES_SVH
`define LINE_PIXEL_GENERATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LPG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define LPG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/lpg_pkg.sv */
// ---------------------------------------------------------------------------
// lpg_pkg
// Types and fixed constants of the line pixel generator.
// ---------------------------------------------------------------------------
package lpg_pkg;

   localparam int SCREEN_BITS    = 10;
   localparam int OUT_COORD_BITS = 10;
   localparam int COLOR_BITS     = 16;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [SCREEN_BITS-1:0] RESET_SCREEN_WIDTH  = 10'd640;
   localparam logic [SCREEN_BITS-1:0] RESET_SCREEN_HEIGHT = 10'd480;

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   typedef enum logic [1:0] {
      KIND_VERT  = 2'd0,
      KIND_HORIZ = 2'd1,
      KIND_BRES  = 2'd2
   } line_kind_type;

   typedef enum logic {
      CSR_SCREEN_WIDTH  = 1'b0,
      CSR_SCREEN_HEIGHT = 1'b1
   } csr_index_type;

   // control half of one queued word
   typedef struct packed {
      logic          is_start;
      logic          busy;
      line_kind_type kind;
      logic          minor_down;
      logic          axes_swapped;
   } cmd_ctrl_type;

endpackage

/* rtl/core/lpg_req_if.sv */
// ---------------------------------------------------------------------------
// lpg_req_if
// Input channel: line start and step words.
// ---------------------------------------------------------------------------
interface lpg_req_if import lpg_pkg::*; #(
   parameter int COORD_BITS = 12
);
   logic                         valid;
   logic                         ready;
   logic                         opcode;
   logic signed [COORD_BITS-1:0] x_start;
   logic signed [COORD_BITS-1:0] y_start;
   logic signed [COORD_BITS-1:0] x_end;
   logic signed [COORD_BITS-1:0] y_end;
   logic [COLOR_BITS-1:0]        color;

   modport source (
      output valid, opcode, x_start, y_start, x_end, y_end, color,
      input  ready
   );
   modport sink (
      input  valid, opcode, x_start, y_start, x_end, y_end, color,
      output ready
   );
endinterface

/* rtl/core/lpg_rsp_if.sv */
// ---------------------------------------------------------------------------
// lpg_rsp_if
// Result channel: one pixel write word per step.
// ---------------------------------------------------------------------------
interface lpg_rsp_if import lpg_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic [OUT_COORD_BITS-1:0] pixel_x;
   logic [OUT_COORD_BITS-1:0] pixel_y;
   logic [COLOR_BITS-1:0]     pixel_color;
   logic                      write_enable;
   logic                      last;

   modport source (
      output valid, pixel_x, pixel_y, pixel_color, write_enable, last,
      input  ready
   );
   modport sink (
      input  valid, pixel_x, pixel_y, pixel_color, write_enable, last,
      output ready
   );
endinterface

/* rtl/core/lpg_front.sv */
// ---------------------------------------------------------------------------
// lpg_front
// Classifies each input word and works out the line set-up for start words.
// ---------------------------------------------------------------------------
module lpg_front import lpg_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  logic                         opcode,
   input  logic signed [COORD_BITS-1:0] x_start,
   input  logic signed [COORD_BITS-1:0] y_start,
   input  logic signed [COORD_BITS-1:0] x_end,
   input  logic signed [COORD_BITS-1:0] y_end,
   input  logic [COLOR_BITS-1:0]        color,
   input  logic [SCREEN_BITS-1:0]       screen_width,
   output cmd_ctrl_type                 cmd_ctrl,
   output logic signed [COORD_BITS-1:0] major_pos,
   output logic signed [COORD_BITS-1:0] major_stop,
   output logic signed [COORD_BITS-1:0] minor_pos,
   output logic [COORD_BITS-1:0]        delta_major,
   output logic [COORD_BITS-1:0]        delta_minor,
   output logic signed [COORD_BITS:0]   error_term,
   output logic [COLOR_BITS-1:0]        line_color
);

   logic signed [COORD_BITS:0]   dx;
   logic signed [COORD_BITS:0]   dy;
   logic [COORD_BITS:0]          adx;
   logic [COORD_BITS:0]          ady;
   logic                         swap;
   logic                         reverse;
   logic signed [COORD_BITS:0]   d_maj;
   logic signed [COORD_BITS:0]   d_min;
   logic signed [COORD_BITS-1:0] maj_a;
   logic signed [COORD_BITS-1:0] maj_b;
   logic signed [COORD_BITS-1:0] min_a;
   logic signed [COORD_BITS-1:0] min_b;
   logic                         x_on_screen;

   assign dx  = {x_end[COORD_BITS-1], x_end} - {x_start[COORD_BITS-1], x_start};
   assign dy  = {y_end[COORD_BITS-1], y_end} - {y_start[COORD_BITS-1], y_start};
   assign adx = dx[COORD_BITS] ? $unsigned(-dx) : $unsigned(dx);
   assign ady = dy[COORD_BITS] ? $unsigned(-dy) : $unsigned(dy);

   // steep lines step along y
   assign swap  = ady > adx;
   assign d_maj = swap ? dy : dx;
   assign d_min = swap ? dx : dy;
   assign maj_a = swap ? y_start : x_start;
   assign maj_b = swap ? y_end : x_end;
   assign min_a = swap ? x_start : y_start;
   assign min_b = swap ? x_end : y_end;
   assign reverse = d_maj[COORD_BITS];

   assign x_on_screen = !x_start[COORD_BITS-1] &&
      ($unsigned(x_start) < {{(COORD_BITS-SCREEN_BITS){1'b0}}, screen_width});

   assign line_color = color;

   always_comb begin
      cmd_ctrl.is_start     = (opcode == OP_START);
      cmd_ctrl.busy         = 1'b1;
      cmd_ctrl.kind         = KIND_BRES;
      cmd_ctrl.minor_down   = 1'b0;
      cmd_ctrl.axes_swapped = 1'b0;
      delta_major           = '0;
      delta_minor           = '0;
      error_term            = '0;
      major_pos             = reverse ? maj_b : maj_a;
      major_stop            = reverse ? maj_a : maj_b;
      minor_pos             = reverse ? min_b : min_a;
      if (x_start == x_end) begin
         // vertical, also a single point; drop it when the column is off screen
         cmd_ctrl.kind = KIND_VERT;
         cmd_ctrl.busy = x_on_screen;
         minor_pos     = x_start;
         major_pos     = dy[COORD_BITS] ? y_end : y_start;
         major_stop    = dy[COORD_BITS] ? y_start : y_end;
      end else if (y_start == y_end) begin
         cmd_ctrl.kind = KIND_HORIZ;
      end else begin
         cmd_ctrl.axes_swapped = swap;
         cmd_ctrl.minor_down   = d_min[COORD_BITS] ^ d_maj[COORD_BITS];
         delta_major           = swap ? ady[COORD_BITS-1:0] : adx[COORD_BITS-1:0];
         delta_minor           = swap ? adx[COORD_BITS-1:0] : ady[COORD_BITS-1:0];
         error_term            = {2'b00, delta_major[COORD_BITS-1:1]};
      end
   end

endmodule

/* rtl/core/lpg_queue.sv */
// ---------------------------------------------------------------------------
// lpg_queue
// Short first-in first-out queue of classified words between front and back.
// ---------------------------------------------------------------------------
module lpg_queue import lpg_pkg::*; #(
   parameter int DATA_BITS = 89
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  cmd_ctrl_type         push_ctrl,
   input  logic [DATA_BITS-1:0] push_data,
   input  logic                 pop,
   output logic                 full,
   output logic                 empty,
   output cmd_ctrl_type         head_ctrl,
   output logic [DATA_BITS-1:0] head_data
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

   cmd_ctrl_type         ctrl_ff [QUEUE_DEPTH];
   logic [DATA_BITS-1:0] data_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]    count_ff, count_in;

   assign full      = (count_ff == (PTR_BITS+1)'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign head_ctrl = ctrl_ff[rd_ptr_ff];
   assign head_data = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (PTR_BITS+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PTR_BITS+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ctrl_ff[wr_ptr_ff] <= push_ctrl;
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/core/lpg_back.sv */
// ---------------------------------------------------------------------------
// lpg_back
// Line stepping engine: loads set-up words and emits one pixel per step word while a line is active.
// ---------------------------------------------------------------------------
module lpg_back import lpg_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  cmd_ctrl_type                  head_ctrl,
   input  logic signed [COORD_BITS-1:0]  head_major_pos,
   input  logic signed [COORD_BITS-1:0]  head_major_stop,
   input  logic signed [COORD_BITS-1:0]  head_minor_pos,
   input  logic [COORD_BITS-1:0]         head_delta_major,
   input  logic [COORD_BITS-1:0]         head_delta_minor,
   input  logic signed [COORD_BITS:0]    head_error_term,
   input  logic [COLOR_BITS-1:0]         head_color,
   input  logic [SCREEN_BITS-1:0]        screen_width,
   input  logic [SCREEN_BITS-1:0]        screen_height,
   output logic                          pop,
   output logic                          line_busy,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [OUT_COORD_BITS-1:0]     rsp_pixel_x,
   output logic [OUT_COORD_BITS-1:0]     rsp_pixel_y,
   output logic [COLOR_BITS-1:0]         rsp_pixel_color,
   output logic                          rsp_write_enable,
   output logic                          rsp_last
);

   localparam logic [COORD_BITS-1:0] COORD_ONE = COORD_BITS'(1);

   logic                         busy_ff, busy_in;
   line_kind_type                kind_ff, kind_in;
   logic signed [COORD_BITS-1:0] major_pos_ff, major_pos_in;
   logic signed [COORD_BITS-1:0] major_stop_ff, major_stop_in;
   logic signed [COORD_BITS-1:0] minor_pos_ff, minor_pos_in;
   logic signed [COORD_BITS:0]   error_ff, error_in;
   logic [COORD_BITS-1:0]        delta_major_ff, delta_major_in;
   logic [COORD_BITS-1:0]        delta_minor_ff, delta_minor_in;
   logic                         minor_down_ff, minor_down_in;
   logic                         swapped_ff, swapped_in;
   logic [COLOR_BITS-1:0]        color_ff, color_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [OUT_COORD_BITS-1:0]    pixel_x_ff, pixel_x_in;
   logic [OUT_COORD_BITS-1:0]    pixel_y_ff, pixel_y_in;
   logic [COLOR_BITS-1:0]        pixel_color_ff, pixel_color_in;
   logic                         write_enable_ff, write_enable_in;
   logic                         last_ff, last_in;

   logic                         out_free;
   logic                         emit;
   logic                         fin;
   logic signed [COORD_BITS-1:0] px;
   logic signed [COORD_BITS-1:0] py;
   logic                         row_clip;
   logic                         col_clip;
   logic signed [COORD_BITS:0]   err_sub;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop       = head_valid && (head_ctrl.is_start || out_free);
   assign emit      = pop && !head_ctrl.is_start && busy_ff;
   assign line_busy = busy_ff;

   assign fin      = major_pos_ff >= major_stop_ff;
   assign row_clip = major_pos_ff[COORD_BITS-1] || ($unsigned(major_pos_ff) >=
      {{(COORD_BITS-SCREEN_BITS){1'b0}}, screen_height});
   assign col_clip = major_pos_ff[COORD_BITS-1] || ($unsigned(major_pos_ff) >=
      {{(COORD_BITS-SCREEN_BITS){1'b0}}, screen_width});
   assign err_sub  = error_ff - $signed({1'b0, delta_minor_ff});

   always_comb begin
      case (kind_ff)
         KIND_VERT: begin
            px = minor_pos_ff;
            py = major_pos_ff;
         end
         KIND_HORIZ: begin
            px = major_pos_ff;
            py = minor_pos_ff;
         end
         default: begin
            px = swapped_ff ? minor_pos_ff : major_pos_ff;
            py = swapped_ff ? major_pos_ff : minor_pos_ff;
         end
      endcase
   end

   always_comb begin
      busy_in        = busy_ff;
      kind_in        = kind_ff;
      major_pos_in   = major_pos_ff;
      major_stop_in  = major_stop_ff;
      minor_pos_in   = minor_pos_ff;
      error_in       = error_ff;
      delta_major_in = delta_major_ff;
      delta_minor_in = delta_minor_ff;
      minor_down_in  = minor_down_ff;
      swapped_in     = swapped_ff;
      color_in       = color_ff;
      if (pop && head_ctrl.is_start) begin
         // a start word always replaces the line in progress
         busy_in        = head_ctrl.busy;
         kind_in        = head_ctrl.kind;
         major_pos_in   = head_major_pos;
         major_stop_in  = head_major_stop;
         minor_pos_in   = head_minor_pos;
         error_in       = head_error_term;
         delta_major_in = head_delta_major;
         delta_minor_in = head_delta_minor;
         minor_down_in  = head_ctrl.minor_down;
         swapped_in     = head_ctrl.axes_swapped;
         color_in       = head_color;
      end else if (emit) begin
         if (fin) begin
            busy_in = 1'b0;
         end else begin
            major_pos_in = major_pos_ff + COORD_ONE;
            if (kind_ff == KIND_BRES) begin
               error_in = err_sub;
               if (err_sub[COORD_BITS]) begin
                  error_in     = err_sub + $signed({1'b0, delta_major_ff});
                  minor_pos_in = minor_down_ff ? minor_pos_ff - COORD_ONE
                                               : minor_pos_ff + COORD_ONE;
               end
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      pixel_x_in      = pixel_x_ff;
      pixel_y_in      = pixel_y_ff;
      pixel_color_in  = pixel_color_ff;
      write_enable_in = write_enable_ff;
      last_in         = last_ff;
      if (emit) begin
         rsp_valid_in    = 1'b1;
         pixel_x_in      = px[OUT_COORD_BITS-1:0];
         pixel_y_in      = py[OUT_COORD_BITS-1:0];
         pixel_color_in  = color_ff;
         last_in         = fin;
         case (kind_ff)
            KIND_VERT:  write_enable_in = !row_clip;
            KIND_HORIZ: write_enable_in = !col_clip;
            default:    write_enable_in = 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         kind_ff      <= KIND_VERT;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      major_pos_ff    <= major_pos_in;
      major_stop_ff   <= major_stop_in;
      minor_pos_ff    <= minor_pos_in;
      error_ff        <= error_in;
      delta_major_ff  <= delta_major_in;
      delta_minor_ff  <= delta_minor_in;
      minor_down_ff   <= minor_down_in;
      swapped_ff      <= swapped_in;
      color_ff        <= color_in;
      pixel_x_ff      <= pixel_x_in;
      pixel_y_ff      <= pixel_y_in;
      pixel_color_ff  <= pixel_color_in;
      write_enable_ff <= write_enable_in;
      last_ff         <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_x      = pixel_x_ff;
   assign rsp_pixel_y      = pixel_y_ff;
   assign rsp_pixel_color  = pixel_color_ff;
   assign rsp_write_enable = write_enable_ff;
   assign rsp_last         = last_ff;

endmodule

/* rtl/core/line_pixel_generator.sv */
// ---------------------------------------------------------------------------
// line_pixel_generator
// Line drawing engine: a start word sets up a line, each step word emits
// one pixel write while a line is active (vertical, horizontal or Bresenham path).
//
//   channel   direction  handshake           carries
//   req_chan  in         valid/ready         opcode, endpoints, colour
//   rsp_chan  out        valid/ready         pixel x/y, colour, write, last
//   csr_*     in         APB, pready high    screen_width @0, screen_height @4
//
// The stepping engine handles each word in a single add/compare/correct step;
// sustained rate is one word per cycle while rsp_ready does not stall it.
// An accepted word passes the queue and the output register before its result.
// Reset is synchronous; no clearing pass.
// rsp_ready low stalls the engine; the four-entry queue absorbs incoming
// words and req_chan.ready drops only when it is full.
// ---------------------------------------------------------------------------
`include "line_pixel_generator_defines.svh"

module line_pixel_generator import lpg_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   lpg_req_if.sink                  req_chan,
   lpg_rsp_if.source                rsp_chan,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int DATA_BITS = COLOR_BITS + 6 * COORD_BITS + 1;

   logic [SCREEN_BITS-1:0]       screen_width_ff, screen_width_in;
   logic [SCREEN_BITS-1:0]       screen_height_ff, screen_height_in;
   logic                         csr_write;
   csr_index_type                csr_index;

   cmd_ctrl_type                 front_ctrl;
   logic signed [COORD_BITS-1:0] front_major_pos;
   logic signed [COORD_BITS-1:0] front_major_stop;
   logic signed [COORD_BITS-1:0] front_minor_pos;
   logic [COORD_BITS-1:0]        front_delta_major;
   logic [COORD_BITS-1:0]        front_delta_minor;
   logic signed [COORD_BITS:0]   front_error;
   logic [COLOR_BITS-1:0]        front_color;
   logic [DATA_BITS-1:0]         push_data;

   logic                         push;
   logic                         pop;
   logic                         q_full;
   logic                         q_empty;
   cmd_ctrl_type                 head_ctrl;
   logic [DATA_BITS-1:0]         head_data;
   logic                         line_busy;

   logic                         step_pop;
   logic                         busy_step;
   logic                         rsp_free;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_index_type'(csr_paddr[2]);

   always_comb begin
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  screen_width_in  = csr_pwdata[SCREEN_BITS-1:0];
            CSR_SCREEN_HEIGHT: screen_height_in = csr_pwdata[SCREEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_SCREEN_WIDTH:  csr_prdata = CSR_DATA_BITS'(screen_width_ff);
         CSR_SCREEN_HEIGHT: csr_prdata = CSR_DATA_BITS'(screen_height_ff);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= RESET_SCREEN_WIDTH;
         screen_height_ff <= RESET_SCREEN_HEIGHT;
      end else begin
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
      end
   end

   // front: classify and set up
   lpg_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .opcode       (req_chan.opcode),
      .x_start      (req_chan.x_start),
      .y_start      (req_chan.y_start),
      .x_end        (req_chan.x_end),
      .y_end        (req_chan.y_end),
      .color        (req_chan.color),
      .screen_width (screen_width_ff),
      .cmd_ctrl     (front_ctrl),
      .major_pos    (front_major_pos),
      .major_stop   (front_major_stop),
      .minor_pos    (front_minor_pos),
      .delta_major  (front_delta_major),
      .delta_minor  (front_delta_minor),
      .error_term   (front_error),
      .line_color   (front_color)
   );

   assign req_chan.ready = !q_full;
   assign push           = req_chan.valid && !q_full;
   assign push_data      = {front_color, front_major_pos, front_major_stop,
                            front_minor_pos, front_delta_major, front_delta_minor,
                            front_error};

   lpg_queue #(
      .DATA_BITS (DATA_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_ctrl (front_ctrl),
      .push_data (push_data),
      .pop       (pop),
      .full      (q_full),
      .empty     (q_empty),
      .head_ctrl (head_ctrl),
      .head_data (head_data)
   );

   // back: step the line
   lpg_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (!q_empty),
      .head_ctrl        (head_ctrl),
      .head_major_pos   (head_data[5*COORD_BITS+1 +: COORD_BITS]),
      .head_major_stop  (head_data[4*COORD_BITS+1 +: COORD_BITS]),
      .head_minor_pos   (head_data[3*COORD_BITS+1 +: COORD_BITS]),
      .head_delta_major (head_data[2*COORD_BITS+1 +: COORD_BITS]),
      .head_delta_minor (head_data[COORD_BITS+1 +: COORD_BITS]),
      .head_error_term  (head_data[COORD_BITS:0]),
      .head_color       (head_data[6*COORD_BITS+1 +: COLOR_BITS]),
      .screen_width     (screen_width_ff),
      .screen_height    (screen_height_ff),
      .pop              (pop),
      .line_busy        (line_busy),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_pixel_x      (rsp_chan.pixel_x),
      .rsp_pixel_y      (rsp_chan.pixel_y),
      .rsp_pixel_color  (rsp_chan.pixel_color),
      .rsp_write_enable (rsp_chan.write_enable),
      .rsp_last         (rsp_chan.last)
   );

   assign step_pop  = pop && !head_ctrl.is_start;
   assign busy_step = step_pop && line_busy;
   assign rsp_free  = !rsp_chan.valid || rsp_chan.ready;

   `LPG_ASSERT_SAME(a_no_pop_empty, clock, reset, q_empty, !pop, "pop from empty queue")
   `LPG_ASSERT_SAME(a_step_needs_slot, clock, reset, step_pop, rsp_free, "step over untaken word")
   `LPG_ASSERT_NEXT(a_step_emits, clock, reset, busy_step, rsp_chan.valid, "no pixel word")

endmodule
